### src/prt_pkg.sv
package prt_pkg;

  // table geometry
  localparam int NUM_SLOTS = 8;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  // configuration port
  localparam int          CFG_AW          = 3;
  localparam logic [31:0] ACK_TIMEOUT_RST = 32'd5000;
  localparam logic        REG_ACK_TIMEOUT = 1'b0;

  // smallest stored attempt count
  localparam logic [7:0] ATTEMPTS_MIN = 8'd1;

  // poll outcome codes
  localparam logic [1:0] RK_NONE   = 2'd0;
  localparam logic [1:0] RK_RESEND = 2'd1;
  localparam logic [1:0] RK_FAILED = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ACK    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_POLL   = 2'd3
  } prt_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } prt_state_t;

  // one table entry as kept in the slot ram
  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] node;
    logic [7:0]  zone;
    logic [7:0]  action;
    logic [15:0] duration;
    logic [7:0]  attempts;
    logic [31:0] sent;
  } prt_slot_t;

  // latched command: op plus an entry image (sent holds the command time)
  typedef struct packed {
    prt_op_t   op;
    prt_slot_t slot;
  } prt_item_t;

  // shared compare unit flags
  typedef struct packed {
    logic match;
    logic expired;
  } prt_cmp_t;

  typedef struct packed {
    logic        success;
    logic [1:0]  retry_kind;
    logic [31:0] node;
    logic [7:0]  zone;
    logic [7:0]  action;
    logic [15:0] duration;
    logic [7:0]  attempts;
  } prt_res_t;

endpackage

### src/prt_ram.sv
module prt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### src/prt_cmp.sv
module prt_cmp
  import prt_pkg::*;
(
  input  prt_item_t   item,
  input  prt_slot_t   slot,
  input  logic [31:0] timeout,
  output prt_cmp_t    flags
);

  logic [31:0] age;

  // key compare and wrapping age against the timeout
  always_comb begin
    age           = item.slot.sent - slot.sent;
    flags.match   = (slot.node == item.slot.node) && (slot.seq == item.slot.seq);
    flags.expired = (age >= timeout);
  end

endmodule

### src/prt_ctrl.sv
module prt_ctrl
  import prt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  prt_item_t        cmd,
  output logic             busy,
  output prt_item_t        item,
  output logic             ram_wr_en,
  output logic [IDX_W-1:0] ram_wr_addr,
  output logic [IDX_W-1:0] ram_rd_addr,
  input  prt_slot_t        ram_rd_data,
  input  prt_cmp_t         flags,
  output logic             res_strobe,
  output prt_res_t         res
);

  prt_state_t           state_r, state_nxt;
  prt_item_t            item_r, item_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;
  logic                 strobe_r, strobe_nxt;
  prt_res_t             res_r, res_nxt;
  logic                 live;
  logic                 hit;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      chk_vld_r <= 1'b0;
      valid_r   <= '0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      chk_vld_r <= chk_vld_nxt;
      valid_r   <= valid_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    chk_idx_r <= chk_idx_nxt;
    res_r     <= res_nxt;
  end

  // hit test for the slot whose ram data is now on hand
  always_comb begin
    live = valid_r[chk_idx_r];
    case (item_r.op) inside
      OP_INSERT:       hit = !live;
      OP_ACK, OP_PEEK: hit = live && flags.match;
      default:         hit = live && flags.expired;
    endcase
  end

  // sequencer: one slot read per cycle, checked the cycle after
  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    cnt_nxt     = cnt_r;
    chk_vld_nxt = 1'b0;
    chk_idx_nxt = chk_idx_r;
    valid_nxt   = valid_r;
    strobe_nxt  = 1'b0;
    res_nxt     = res_r;
    ram_rd_addr = cnt_r[IDX_W-1:0];
    ram_wr_en   = 1'b0;
    ram_wr_addr = chk_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt = cmd;
          if (cmd.slot.attempts == '0) begin
            item_nxt.slot.attempts = ATTEMPTS_MIN;
          end
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue the next slot read
        if (cnt_r < CNT_W'(NUM_SLOTS)) begin
          cnt_nxt     = cnt_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = cnt_r[IDX_W-1:0];
        end
        // finish on a hit or after the last slot
        if (chk_vld_r && (hit || cnt_r == CNT_W'(NUM_SLOTS))) begin
          state_nxt   = ST_IDLE;
          chk_vld_nxt = 1'b0;
          strobe_nxt  = 1'b1;
          res_nxt     = '0;
          if (hit) begin
            unique case (item_r.op)
              OP_INSERT: begin
                res_nxt.success      = 1'b1;
                ram_wr_en            = 1'b1;
                valid_nxt[chk_idx_r] = 1'b1;
              end
              OP_ACK: begin
                res_nxt.success      = 1'b1;
                valid_nxt[chk_idx_r] = 1'b0;
              end
              OP_PEEK: begin
                res_nxt.success = 1'b1;
                res_nxt.zone    = ram_rd_data.zone;
                res_nxt.action  = ram_rd_data.action;
              end
              OP_POLL: begin
                res_nxt.node         = ram_rd_data.node;
                res_nxt.zone         = ram_rd_data.zone;
                res_nxt.action       = ram_rd_data.action;
                res_nxt.duration     = ram_rd_data.duration;
                valid_nxt[chk_idx_r] = 1'b0;
                if (ram_rd_data.attempts > ATTEMPTS_MIN) begin
                  res_nxt.retry_kind = RK_RESEND;
                  res_nxt.attempts   = ram_rd_data.attempts - ATTEMPTS_MIN;
                end else begin
                  res_nxt.retry_kind = RK_FAILED;
                  res_nxt.attempts   = ram_rd_data.attempts;
                end
              end
              default: res_nxt = '0;
            endcase
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy       = (state_r == ST_SCAN);
  assign item       = item_r;
  assign res_strobe = strobe_r;
  assign res        = res_r;

endmodule

### src/pending_command_retry_table.sv
// Pending command retry table.
// Command channel: a command (in_op and its fields) is taken at a rising
// edge where start is high and busy is low. in_op selects insert (store in
// the lowest free slot), ack (free the lowest slot matching node and seq),
// peek (report zone and action of that match) or poll (free the lowest slot
// whose wrapping age now_ms - sent time has reached the ack timeout and
// report resend or failed).
// Result channel: every command gives exactly one result, shown for one
// cycle with out_strobe high. The receiver cannot stall; a result must be
// taken in the cycle it is shown.
// Timing: the sequencer walks the slot ram from slot 0, one slot per cycle,
// a slot's check following in the cycle after its read, and stops at the
// first hit or after the last slot, registering the result. busy drops
// with the result, so a new command can be taken at the edge that ends the
// result cycle.
// Configuration: the ack timeout at APB byte address 0; the user writes it
// only while busy is low, which the block does not enforce. Reset empties
// the table and loads a timeout of 5000 ms; no clearing pass is needed.
module pending_command_retry_table
  import prt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // command channel
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_op,
  input  logic [31:0]       in_seq,
  input  logic [31:0]       in_node,
  input  logic [7:0]        in_zone,
  input  logic [7:0]        in_action,
  input  logic [15:0]       in_duration,
  input  logic [7:0]        in_attempts,
  input  logic [31:0]       in_now_ms,
  // result channel
  output logic              out_strobe,
  output logic              out_success,
  output logic [1:0]        out_retry_kind,
  output logic [31:0]       out_node,
  output logic [7:0]        out_zone,
  output logic [7:0]        out_action,
  output logic [15:0]       out_duration,
  output logic [7:0]        out_attempts
);

  logic [31:0]      ack_timeout_r;
  prt_item_t        cmd;
  prt_item_t        item;
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  logic [IDX_W-1:0] ram_rd_addr;
  prt_slot_t        ram_rd_data;
  prt_cmp_t         flags;
  prt_res_t         res;

  // register write on the access transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (psel && penable && pwrite && pready
                 && paddr[CFG_AW-1] == REG_ACK_TIMEOUT) begin
      ack_timeout_r <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[CFG_AW-1] == REG_ACK_TIMEOUT) ? ack_timeout_r : '0;

  // gather the command fields
  always_comb begin
    cmd.op            = prt_op_t'(in_op);
    cmd.slot.seq      = in_seq;
    cmd.slot.node     = in_node;
    cmd.slot.zone     = in_zone;
    cmd.slot.action   = in_action;
    cmd.slot.duration = in_duration;
    cmd.slot.attempts = in_attempts;
    cmd.slot.sent     = in_now_ms;
  end

  prt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .cmd         (cmd),
    .busy        (busy),
    .item        (item),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .flags       (flags),
    .res_strobe  (out_strobe),
    .res         (res)
  );

  prt_ram #(
    .WIDTH ($bits(prt_slot_t)),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (item.slot),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  prt_cmp u_cmp (
    .item    (item),
    .slot    (ram_rd_data),
    .timeout (ack_timeout_r),
    .flags   (flags)
  );

  assign out_success    = res.success;
  assign out_retry_kind = res.retry_kind;
  assign out_node       = res.node;
  assign out_zone       = res.zone;
  assign out_action     = res.action;
  assign out_duration   = res.duration;
  assign out_attempts   = res.attempts;

  // a result only closes a command that was in progress
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a command in progress");

  // an accepted command keeps the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after command transfer");

  // a poll outcome never comes with success set
  a_poll_no_success: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_retry_kind != RK_NONE) |-> !out_success)
    else $error("poll outcome with success set");

  // only defined outcome codes leave the block
  a_retry_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_retry_kind == RK_NONE || out_retry_kind == RK_RESEND
                    || out_retry_kind == RK_FAILED))
    else $error("undefined retry code");

endmodule
